// File: hw/rtl/two_class_ordered_queue_defines.svh
// Assertion macros for the two-class ordered queue.
`ifndef TWO_CLASS_ORDERED_QUEUE_DEFINES_SVH
`define TWO_CLASS_ORDERED_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define TCOQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tcoq: same-cycle check failed");
`define TCOQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcoq: next-cycle check failed");
`else
`define TCOQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TCOQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hw/rtl/tcoq_pkg.sv
// Shared beat types and command and status codes of the two-class ordered queue.
package tcoq_pkg;

  localparam int unsigned IN_TAG_W = 16;

  typedef enum logic [1:0] {
    CMD_ENQ     = 2'd0,
    CMD_DEQ_ANY = 2'd1,
    CMD_DEQ_C0  = 2'd2,
    CMD_DEQ_C1  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                cmd;
    logic                item_class;
    logic [IN_TAG_W-1:0] item_tag;
  } in_beat_t;

  typedef struct packed {
    status_e             status;
    logic                out_class;
    logic [IN_TAG_W-1:0] out_tag;
  } out_beat_t;

endpackage

// File: hw/rtl/tcoq_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module tcoq_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/two_class_ordered_queue.sv
// Two-class ordered queue: a main FIFO and a skip FIFO in two RAMs, with class dequeue.
// Works on one item at a time; an enqueue, or any command on an empty queue, passes its
// result beat through S_EMIT to the output register, a dequeue of any class through S_ANY and S_EMIT.
// A class dequeue checks the skip head in S_CHK if the skip FIFO holds entries, then in S_MOVE
// moves one main entry per cycle into the skip FIFO, paced by the registered read of the main RAM.
// Reset clears the controller, heads and fill counts; RAM contents are left as they are.
`include "two_class_ordered_queue_defines.svh"

module two_class_ordered_queue
  import tcoq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = TAG_BITS + 1;
  localparam int KEEP_W = (TAG_BITS < IN_TAG_W) ? TAG_BITS : IN_TAG_W;
  localparam logic [CNT_W:0] DEPTH_OCC = (CNT_W + 1)'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANY,
    S_CHK,
    S_MOVE,
    S_EMIT
  } state_e;

  // Add an offset to a ring position, wrapping at the queue depth.
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
    if (sum >= DEPTH_OCC) begin
      sum = sum - DEPTH_OCC;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic out_beat_t mk_res(status_e st, logic have, logic [ENT_W-1:0] e);
    out_beat_t r;
    r.status    = st;
    r.out_class = have ? e[TAG_BITS] : 1'b0;
    r.out_tag   = have ? IN_TAG_W'(e[KEEP_W-1:0]) : '0;
    return r;
  endfunction

  state_e           state_q, state_d;
  logic [PTR_W-1:0] main_head_q, main_head_d;
  logic [CNT_W-1:0] main_cnt_q, main_cnt_d;
  logic [PTR_W-1:0] skip_head_q, skip_head_d;
  logic [CNT_W-1:0] skip_cnt_q, skip_cnt_d;
  logic             want_q, want_d;
  logic             from_skip_q, from_skip_d;
  out_beat_t        res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  logic             main_we, skip_we;
  logic [PTR_W-1:0] main_waddr, main_raddr, skip_waddr, skip_raddr;
  logic [ENT_W-1:0] main_wdata, main_rdata, skip_wdata, skip_rdata;
  logic [ENT_W-1:0] new_entry;
  logic [CNT_W:0]   occ;
  logic             full;

  assign occ       = {1'b0, main_cnt_q} + {1'b0, skip_cnt_q};
  assign full      = (occ >= DEPTH_OCC);
  assign new_entry = {in_data_i.item_class, TAG_BITS'(in_data_i.item_tag[KEEP_W-1:0])};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    main_head_d = main_head_q;
    main_cnt_d  = main_cnt_q;
    skip_head_d = skip_head_q;
    skip_cnt_d  = skip_cnt_q;
    want_d      = want_q;
    from_skip_d = from_skip_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    main_we    = 1'b0;
    main_waddr = wrap_add(main_head_q, main_cnt_q);
    main_wdata = new_entry;
    main_raddr = main_head_q;
    skip_we    = 1'b0;
    skip_waddr = wrap_add(skip_head_q, skip_cnt_q);
    skip_wdata = main_rdata;
    skip_raddr = skip_head_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          want_d  = (in_data_i.cmd == CMD_DEQ_C1);
          res_d   = mk_res(ST_OK, 1'b0, '0);
          state_d = S_EMIT;
          priority if (in_data_i.cmd == CMD_ENQ) begin
            if (full) begin
              res_d = mk_res(ST_FULL, 1'b0, '0);
            end else begin
              main_we    = 1'b1;
              main_cnt_d = main_cnt_q + CNT_W'(1);
            end
          end else if (main_cnt_q == '0 && skip_cnt_q == '0) begin
            res_d = mk_res(ST_EMPTY, 1'b0, '0);
          end else if (in_data_i.cmd == CMD_DEQ_ANY) begin
            from_skip_d = (skip_cnt_q != '0);
            if (skip_cnt_q != '0) begin
              skip_head_d = wrap_add(skip_head_q, CNT_W'(1));
              skip_cnt_d  = skip_cnt_q - CNT_W'(1);
            end else begin
              main_head_d = wrap_add(main_head_q, CNT_W'(1));
              main_cnt_d  = main_cnt_q - CNT_W'(1);
            end
            state_d = S_ANY;
          end else if (skip_cnt_q != '0) begin
            state_d = S_CHK;
          end else begin
            main_head_d = wrap_add(main_head_q, CNT_W'(1));
            main_cnt_d  = main_cnt_q - CNT_W'(1);
            state_d     = S_MOVE;
          end
        end
      end
      S_ANY: begin
        res_d   = mk_res(ST_OK, 1'b1, from_skip_q ? skip_rdata : main_rdata);
        state_d = S_EMIT;
      end
      S_CHK: begin
        if (skip_rdata[TAG_BITS] == want_q) begin
          skip_head_d = wrap_add(skip_head_q, CNT_W'(1));
          skip_cnt_d  = skip_cnt_q - CNT_W'(1);
          res_d       = mk_res(ST_OK, 1'b1, skip_rdata);
          state_d     = S_EMIT;
        end else if (main_cnt_q == '0) begin
          res_d   = mk_res(ST_NOMATCH, 1'b0, '0);
          state_d = S_EMIT;
        end else begin
          main_head_d = wrap_add(main_head_q, CNT_W'(1));
          main_cnt_d  = main_cnt_q - CNT_W'(1);
          state_d     = S_MOVE;
        end
      end
      S_MOVE: begin
        // The main RAM is read at the head every cycle; the entry is popped only
        // when the previous one did not match.
        if (main_rdata[TAG_BITS] == want_q) begin
          res_d   = mk_res(ST_OK, 1'b1, main_rdata);
          state_d = S_EMIT;
        end else begin
          skip_we    = 1'b1;
          skip_cnt_d = skip_cnt_q + CNT_W'(1);
          if (main_cnt_q != '0) begin
            main_head_d = wrap_add(main_head_q, CNT_W'(1));
            main_cnt_d  = main_cnt_q - CNT_W'(1);
          end else begin
            res_d   = mk_res(ST_NOMATCH, 1'b0, '0);
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      main_head_q <= '0;
      main_cnt_q  <= '0;
      skip_head_q <= '0;
      skip_cnt_q  <= '0;
      want_q      <= 1'b0;
      from_skip_q <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      main_head_q <= main_head_d;
      main_cnt_q  <= main_cnt_d;
      skip_head_q <= skip_head_d;
      skip_cnt_q  <= skip_cnt_d;
      want_q      <= want_d;
      from_skip_q <= from_skip_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  tcoq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  tcoq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_skip_ram (
    .clk_i   (clk_i),
    .we_i    (skip_we),
    .waddr_i (skip_waddr),
    .wdata_i (skip_wdata),
    .raddr_i (skip_raddr),
    .rdata_o (skip_rdata)
  );

  // The two FIFOs share one capacity, so the skip FIFO never overflows during moves.
  `TCOQ_ASSERT_IMPL(a_occ_bound, clk_i, rst_ni, 1'b1, occ <= DEPTH_OCC)
  `TCOQ_ASSERT_IMPL(a_main_waddr, clk_i, rst_ni, main_we, main_waddr < QUEUE_DEPTH)
  `TCOQ_ASSERT_IMPL(a_skip_waddr, clk_i, rst_ni, skip_we, skip_waddr < QUEUE_DEPTH)
  `TCOQ_ASSERT_IMPL(a_empty_result, clk_i, rst_ni,
    out_valid_o && out_data_o.status != ST_OK,
    out_data_o.out_class == 1'b0 && out_data_o.out_tag == '0)
  `TCOQ_ASSERT_NEXT(a_full_drop, clk_i, rst_ni,
    in_valid_i && !in_stall_o && in_data_i.cmd == CMD_ENQ && full,
    main_cnt_q == $past(main_cnt_q))

endmodule
